>>> design/qhd_pkg.sv
// shared types and constants for the q-gram hash extractor
`default_nettype none

package qhd_pkg;

    // sizes
    localparam int SEEN_DEPTH_DEF = 64;
    localparam int BYTE_W         = 8;
    localparam int HASH_W         = 32;
    localparam int HASH_SHIFT     = 5;
    localparam int QLEN_W         = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAM_LENGTH    = 3'd0,
        CFG_EXTENDED_MODE  = 3'd1,
        CFG_START_PAD_CHAR = 3'd2,
        CFG_END_PAD_CHAR   = 3'd3,
        CFG_UNIQUE_MODE    = 3'd4
    } cfg_idx_t;

    // where the byte being pushed comes from
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_START,
        SRC_CHAR,
        SRC_END
    } src_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_PUSH,
        S_HASH,
        S_SCAN,
        S_EMIT,
        S_FLUSH
    } ctl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic        capture;
        logic        set_started;
        src_t        src;
        logic        hash_step;
        logic [1:0]  hash_idx;
        logic        scan_start;
        logic        scan_step;
        logic        record;
        logic        shift;
        logic        commit;
        logic        pend_to_out;
        logic        last;
        logic        end_string;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [QLEN_W-1:0] gram_len;
        logic              ext;
        logic              uniq;
        logic              started;
        logic              has_char;
        logic              eos;
        logic              eligible;
        logic              scan_hit;
        logic              scan_done;
        logic              pend_valid;
        logic              out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> design/qhd_ctrl.sv
// controller state machine: sequences pads, byte, hashing, store search and output
`default_nettype none

module qhd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire qhd_pkg::dp_sts_t sts,
    output qhd_pkg::dp_cmd_t     cmd
);
    import qhd_pkg::*;

    ctl_state_t state_reg, state_next;
    src_t       src_reg, src_next;
    logic [1:0] left_reg, left_next;
    logic [1:0] hidx_reg, hidx_next;

    logic [1:0] qm1;
    logic [1:0] end_cnt;
    logic       start_go;
    logic       adv_valid;
    src_t       adv_src;
    logic [1:0] adv_left;
    logic       go_adv;
    logic       hash_end;

    // which push follows the current one
    always_comb
    begin
        qm1      = sts.gram_len - 2'd1;
        end_cnt  = (sts.eos && sts.ext) ? qm1 : 2'd0;
        start_go = !sts.started && sts.ext && (qm1 != 2'd0);
        adv_valid = 1'b0;
        adv_src   = SRC_NONE;
        adv_left  = 2'd0;
        case (src_reg)
            SRC_NONE:
            begin
                if (start_go)
                begin
                    adv_valid = 1'b1;
                    adv_src   = SRC_START;
                    adv_left  = qm1;
                end
                else if (sts.has_char)
                begin
                    adv_valid = 1'b1;
                    adv_src   = SRC_CHAR;
                    adv_left  = 2'd1;
                end
                else if (end_cnt != 2'd0)
                begin
                    adv_valid = 1'b1;
                    adv_src   = SRC_END;
                    adv_left  = end_cnt;
                end
            end
            SRC_START:
            begin
                if (left_reg > 2'd1)
                begin
                    adv_valid = 1'b1;
                    adv_src   = SRC_START;
                    adv_left  = left_reg - 2'd1;
                end
                else if (sts.has_char)
                begin
                    adv_valid = 1'b1;
                    adv_src   = SRC_CHAR;
                    adv_left  = 2'd1;
                end
                else if (end_cnt != 2'd0)
                begin
                    adv_valid = 1'b1;
                    adv_src   = SRC_END;
                    adv_left  = end_cnt;
                end
            end
            SRC_CHAR:
            begin
                if (end_cnt != 2'd0)
                begin
                    adv_valid = 1'b1;
                    adv_src   = SRC_END;
                    adv_left  = end_cnt;
                end
            end
            default:
            begin
                if (left_reg > 2'd1)
                begin
                    adv_valid = 1'b1;
                    adv_src   = SRC_END;
                    adv_left  = left_reg - 2'd1;
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            src_reg   <= SRC_NONE;
            left_reg  <= 2'd0;
            hidx_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
            left_reg  <= left_next;
            hidx_reg  <= hidx_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd          = '0;
        cmd.src      = src_reg;
        cmd.hash_idx = hidx_reg;
        in_ready     = 1'b0;
        state_next   = state_reg;
        src_next     = src_reg;
        left_next    = left_reg;
        hidx_next    = hidx_reg;
        go_adv       = 1'b0;
        hash_end     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    src_next    = SRC_NONE;
                    left_next   = 2'd0;
                    state_next  = S_PLAN;
                end
            end
            S_PLAN:
            begin
                if (sts.gram_len == 2'd0)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.set_started = 1'b1;
                    go_adv          = 1'b1;
                end
            end
            S_PUSH:
            begin
                if (sts.eligible)
                begin
                    cmd.hash_step = 1'b1;
                    cmd.hash_idx  = 2'd0;
                    hidx_next     = 2'd1;
                    if (qm1 == 2'd0)
                    begin
                        hash_end = 1'b1;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
                else
                begin
                    cmd.shift = 1'b1;
                    go_adv    = 1'b1;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                hidx_next     = hidx_reg + 2'd1;
                if (hidx_reg == qm1)
                begin
                    hash_end = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    // duplicate: drop the gram, window still moves on
                    cmd.shift = 1'b1;
                    go_adv    = 1'b1;
                end
                else if (sts.scan_done)
                begin
                    cmd.record = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.commit      = 1'b1;
                    cmd.shift       = 1'b1;
                    cmd.pend_to_out = sts.pend_valid;
                    cmd.last        = 1'b0;
                    go_adv          = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.pend_to_out = sts.pend_valid;
                    cmd.last        = 1'b1;
                    cmd.end_string  = sts.eos;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hashing finished: search the store or go straight to output
        if (hash_end)
        begin
            if (sts.uniq)
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            else
            begin
                state_next = S_EMIT;
            end
        end

        // move on to the next push or finish the item
        if (go_adv)
        begin
            if (adv_valid)
            begin
                state_next = S_PUSH;
                src_next   = adv_src;
                left_next  = adv_left;
            end
            else
            begin
                state_next = S_FLUSH;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/qhd_datapath.sv
// datapath: config registers, window, hash unit, seen-hash store and output buffers
`default_nettype none

module qhd_datapath #(
    parameter int SEEN_DEPTH = qhd_pkg::SEEN_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [qhd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [qhd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [qhd_pkg::BYTE_W-1:0]      char_byte,
    input  wire logic                            has_char,
    input  wire logic                            end_of_string,
    input  wire qhd_pkg::dp_cmd_t                cmd,
    output qhd_pkg::dp_sts_t                     sts,
    output logic [qhd_pkg::BYTE_W-1:0]           gram_byte0,
    output logic [qhd_pkg::BYTE_W-1:0]           gram_byte1,
    output logic [qhd_pkg::BYTE_W-1:0]           gram_byte2,
    output logic [qhd_pkg::HASH_W-1:0]           gram_hash,
    output logic                                 store_full,
    output logic                                 last_of_run,
    output logic                                 out_valid,
    input  wire logic                            out_ready
);
    import qhd_pkg::*;

    localparam int AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int CW = $clog2(SEEN_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(SEEN_DEPTH);

    // times-33 xor step on a sign-extended byte
    function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] c;
        begin
            c = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
            return ((h << HASH_SHIFT) + h) ^ c;
        end
    endfunction

    logic [QLEN_W-1:0] qlen_reg;
    logic              ext_reg;
    logic [BYTE_W-1:0] spad_reg;
    logic [BYTE_W-1:0] epad_reg;
    logic              uniq_reg;

    logic [BYTE_W-1:0] ch_reg;
    logic              hc_reg;
    logic              eos_reg;

    logic [BYTE_W-1:0] win0_reg, win1_reg;
    logic [1:0]        fill_reg;
    logic              started_reg;

    logic [BYTE_W-1:0] push_byte;
    logic [BYTE_W-1:0] g0, g1, g2;
    logic [BYTE_W-1:0] hash_byte;
    logic [HASH_W-1:0] hash_reg;
    logic              full_reg;

    logic [HASH_W-1:0] seen_mem [SEEN_DEPTH];
    logic [HASH_W-1:0] mem_q_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     issue_reg;
    logic              rd_pend_reg;
    logic              mem_we;
    logic              mem_re;

    logic              pend_valid_reg;
    logic [BYTE_W-1:0] pend_g0_reg, pend_g1_reg, pend_g2_reg;
    logic [HASH_W-1:0] pend_hash_reg;
    logic              pend_full_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_g0_reg, out_g1_reg, out_g2_reg;
    logic [HASH_W-1:0] out_hash_reg;
    logic              out_full_reg;
    logic              out_last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg <= 2'd2;
            ext_reg  <= 1'b0;
            spad_reg <= 8'd35;
            epad_reg <= 8'd36;
            uniq_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRAM_LENGTH:    qlen_reg <= cfg_data[QLEN_W-1:0];
                CFG_EXTENDED_MODE:  ext_reg  <= cfg_data[0];
                CFG_START_PAD_CHAR: spad_reg <= cfg_data;
                CFG_END_PAD_CHAR:   epad_reg <= cfg_data;
                CFG_UNIQUE_MODE:    uniq_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // captured input beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg  <= char_byte;
            hc_reg  <= has_char;
            eos_reg <= end_of_string;
        end
    end

    // byte being pushed into the window
    always_comb
    begin
        case (cmd.src)
            SRC_START: push_byte = spad_reg;
            SRC_END:   push_byte = epad_reg;
            default:   push_byte = ch_reg;
        endcase
    end

    // gram made of the newest window bytes and the pushed byte
    always_comb
    begin
        g0 = '0;
        g1 = '0;
        g2 = '0;
        case (qlen_reg)
            2'd1:
            begin
                g0 = push_byte;
            end
            2'd2:
            begin
                g0 = win1_reg;
                g1 = push_byte;
            end
            2'd3:
            begin
                g0 = win0_reg;
                g1 = win1_reg;
                g2 = push_byte;
            end
            default:
            begin
                g0 = '0;
            end
        endcase
    end

    // sliding window and string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg    <= '0;
            win1_reg    <= '0;
            fill_reg    <= 2'd0;
            started_reg <= 1'b0;
        end
        else if (cmd.end_string)
        begin
            win0_reg    <= '0;
            win1_reg    <= '0;
            fill_reg    <= 2'd0;
            started_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_started)
            begin
                started_reg <= 1'b1;
            end
            if (cmd.shift)
            begin
                win0_reg <= win1_reg;
                win1_reg <= push_byte;
                if (fill_reg < 2'd2)
                begin
                    fill_reg <= fill_reg + 2'd1;
                end
            end
        end
    end

    // hash unit, one gram byte per cycle
    always_comb
    begin
        case (cmd.hash_idx)
            2'd0:    hash_byte = g0;
            2'd1:    hash_byte = g1;
            default: hash_byte = g2;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hash_step)
        begin
            hash_reg <= mix_byte((cmd.hash_idx == 2'd0) ? '0 : hash_reg, hash_byte);
        end
        if (cmd.hash_step && (cmd.hash_idx == 2'd0))
        begin
            full_reg <= 1'b0;
        end
        else if (cmd.record)
        begin
            full_reg <= !(count_reg < DEPTH_C);
        end
    end

    // seen-hash store: one write and one read port
    assign mem_we = cmd.record && (count_reg < DEPTH_C);
    assign mem_re = cmd.scan_step && (issue_reg < count_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seen_mem[count_reg[AW-1:0]] <= hash_reg;
        end
        if (mem_re)
        begin
            mem_q_reg <= seen_mem[issue_reg[AW-1:0]];
        end
    end

    // fill count and search pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            issue_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.end_string)
            begin
                count_reg <= '0;
            end
            else if (mem_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.scan_start)
            begin
                issue_reg   <= '0;
                rd_pend_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_pend_reg <= mem_re;
                if (mem_re)
                begin
                    issue_reg <= issue_reg + CW'(1);
                end
            end
        end
    end

    // pending gram, held until it is known whether another follows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.pend_to_out)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            pend_g0_reg   <= g0;
            pend_g1_reg   <= g1;
            pend_g2_reg   <= g2;
            pend_hash_reg <= hash_reg;
            pend_full_reg <= full_reg && uniq_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.pend_to_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pend_to_out)
        begin
            out_g0_reg   <= pend_g0_reg;
            out_g1_reg   <= pend_g1_reg;
            out_g2_reg   <= pend_g2_reg;
            out_hash_reg <= pend_hash_reg;
            out_full_reg <= pend_full_reg;
            out_last_reg <= cmd.last;
        end
    end

    assign gram_byte0  = out_g0_reg;
    assign gram_byte1  = out_g1_reg;
    assign gram_byte2  = out_g2_reg;
    assign gram_hash   = out_hash_reg;
    assign store_full  = out_full_reg;
    assign last_of_run = out_last_reg;
    assign out_valid   = out_valid_reg;

    // status to the controller
    always_comb
    begin
        sts.gram_len   = qlen_reg;
        sts.ext        = ext_reg;
        sts.uniq       = uniq_reg;
        sts.started    = started_reg;
        sts.has_char   = hc_reg;
        sts.eos        = eos_reg;
        sts.eligible   = ({1'b0, fill_reg} + 3'd1) >= {1'b0, qlen_reg};
        sts.scan_hit   = rd_pend_reg && (mem_q_reg == hash_reg);
        sts.scan_done  = !rd_pend_reg && (issue_reg == count_reg);
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

>>> design/qgram_hash_dedup.sv
// an item is taken in idle, planned, and ended in flush; a pushed byte making no gram
// only shifts the window, else its gram is hashed byte by byte, searched for in the
// seen store in unique mode (a duplicate ends the search and is dropped) and emitted,
// waiting while the output register is full; the end-of-item step waits likewise.
// throughput: one item at a time; the output register lets the next item in while
// the last gram waits. reset clears control state and the fill count, not the store.
`default_nettype none

module qgram_hash_dedup #(
    parameter int SEEN_DEPTH = qhd_pkg::SEEN_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [qhd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [qhd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [qhd_pkg::BYTE_W-1:0]      char_byte,
    input  wire logic                            has_char,
    input  wire logic                            end_of_string,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [qhd_pkg::BYTE_W-1:0]           gram_byte0,
    output logic [qhd_pkg::BYTE_W-1:0]           gram_byte1,
    output logic [qhd_pkg::BYTE_W-1:0]           gram_byte2,
    output logic [qhd_pkg::HASH_W-1:0]           gram_hash,
    output logic                                 store_full,
    output logic                                 last_of_run
);
    import qhd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencing
    qhd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // window, hash, store and output
    qhd_datapath #(
        .SEEN_DEPTH (SEEN_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .char_byte     (char_byte),
        .has_char      (has_char),
        .end_of_string (end_of_string),
        .cmd           (cmd),
        .sts           (sts),
        .gram_byte0    (gram_byte0),
        .gram_byte1    (gram_byte1),
        .gram_byte2    (gram_byte2),
        .gram_hash     (gram_hash),
        .store_full    (store_full),
        .last_of_run   (last_of_run),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

`ifndef SYNTH
    // a new beat is only taken once the previous item's grams have all left the buffer
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.pend_valid)
        else $error("input taken while a gram is still pending");

    // a gram only moves to the output register when that register is free
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pend_to_out |-> sts.out_free)
        else $error("output register overwritten");

    // the store is never written while the hash is still being built
    a_record_after_hash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.record |-> !cmd.hash_step && !cmd.scan_start)
        else $error("store write during hashing");

    // a released gram appears at the output in the next cycle
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pend_to_out |=> out_valid)
        else $error("released gram missing at output");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// testbench for the q-gram hash extractor: directed and random strings checked against a predictor
`default_nettype none

module tb_top;
    import qhd_pkg::*;

    localparam int STORE_DEPTH   = SEEN_DEPTH_DEF;
    localparam int MAX_GRAMS     = 3;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 200;

    // one emitted gram as the block should present it
    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [HASH_W-1:0] hash;
        logic              full;
        logic              last;
    } gram_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     char_byte;
    logic                  has_char;
    logic                  end_of_string;
    logic                  out_valid;
    logic                  out_ready;
    logic [BYTE_W-1:0]     gram_byte0;
    logic [BYTE_W-1:0]     gram_byte1;
    logic [BYTE_W-1:0]     gram_byte2;
    logic [HASH_W-1:0]     gram_hash;
    logic                  store_full;
    logic                  last_of_run;

    // predictor copy of the registers
    logic [QLEN_W-1:0]     cfg_gram_len;
    logic                  cfg_ext;
    logic [BYTE_W-1:0]     cfg_spad;
    logic [BYTE_W-1:0]     cfg_epad;
    logic                  cfg_uniq;

    // predictor copy of the string state
    logic [BYTE_W-1:0]     win_old;
    logic [BYTE_W-1:0]     win_new;
    int                    win_fill;
    bit                    str_open;
    logic [HASH_W-1:0]     seen_list[$];

    gram_t                 item_grams[$];
    gram_t                 pending_grams[$];

    int                    err_count;
    int unsigned           hold_len;
    bit                    rush_input;
    bit                    rush_output;

    qgram_hash_dedup u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_byte     (char_byte),
        .has_char      (has_char),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gram_byte0    (gram_byte0),
        .gram_byte1    (gram_byte1),
        .gram_byte2    (gram_byte2),
        .gram_hash     (gram_hash),
        .store_full    (store_full),
        .last_of_run   (last_of_run)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // one step of the times-33 xor hash, byte taken as signed
    function automatic logic [HASH_W-1:0] times33_xor(logic [HASH_W-1:0] h,
                                                      logic [BYTE_W-1:0] b);
        return ((h << HASH_SHIFT) + h) ^ {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    function automatic bit hash_known(logic [HASH_W-1:0] h);
        foreach (seen_list[k])
        begin
            if (seen_list[k] == h)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_string();
        win_old  = '0;
        win_new  = '0;
        win_fill = 0;
        str_open = 1'b0;
        seen_list.delete();
    endfunction

    // push one byte through the window, collecting any gram it completes
    function automatic void shift_in(logic [BYTE_W-1:0] b);
        gram_t g;
        int    q;
        bit    keep;
        q    = int'(cfg_gram_len);
        g    = '0;
        keep = 1'b1;
        if (win_fill + 1 >= q)
        begin
            case (q)
                1: g.b0 = b;
                2:
                begin
                    g.b0 = win_new;
                    g.b1 = b;
                end
                default:
                begin
                    g.b0 = win_old;
                    g.b1 = win_new;
                    g.b2 = b;
                end
            endcase
            g.hash = times33_xor('0, g.b0);
            if (q >= 2)
                g.hash = times33_xor(g.hash, g.b1);
            if (q >= 3)
                g.hash = times33_xor(g.hash, g.b2);
            // duplicate suppression within the string
            if (cfg_uniq)
            begin
                if (hash_known(g.hash))
                    keep = 1'b0;
                else if (seen_list.size() < STORE_DEPTH)
                    seen_list.push_back(g.hash);
                else
                    g.full = 1'b1;
            end
            if (keep && item_grams.size() < MAX_GRAMS)
                item_grams.push_back(g);
        end
        win_old = win_new;
        win_new = b;
        if (win_fill < 2)
            win_fill++;
    endfunction

    // expected grams for one accepted beat
    function automatic void predict_grams(logic [BYTE_W-1:0] b, bit has, bit eos);
        gram_t tail;
        int    i;
        item_grams.delete();
        if (cfg_gram_len != 0)
        begin
            if (!str_open)
            begin
                if (cfg_ext)
                    for (i = 0; i + 1 < int'(cfg_gram_len); i++)
                        shift_in(cfg_spad);
                str_open = 1'b1;
            end
            if (has)
                shift_in(b);
            if (eos && cfg_ext)
                for (i = 0; i + 1 < int'(cfg_gram_len); i++)
                    shift_in(cfg_epad);
        end
        if (item_grams.size() != 0)
        begin
            tail      = item_grams.pop_back();
            tail.last = 1'b1;
            item_grams.push_back(tail);
        end
        foreach (item_grams[k])
            pending_grams.push_back(item_grams[k]);
        if (eos)
            clear_string();
    endfunction

    task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                   input logic [HASH_W-1:0] want);
        if (err_count < MAX_REPORTS)
            $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
        err_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin : check_beat
        gram_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_grams.size() == 0)
                report_mismatch("unexpected gram hash", gram_hash, '0);
            else
            begin
                want = pending_grams.pop_front();
                if (gram_byte0 !== want.b0)
                    report_mismatch("gram_byte0", gram_byte0, want.b0);
                if (gram_byte1 !== want.b1)
                    report_mismatch("gram_byte1", gram_byte1, want.b1);
                if (gram_byte2 !== want.b2)
                    report_mismatch("gram_byte2", gram_byte2, want.b2);
                if (gram_hash !== want.hash)
                    report_mismatch("gram_hash", gram_hash, want.hash);
                if (store_full !== want.full)
                    report_mismatch("store_full", store_full, want.full);
                if (last_of_run !== want.last)
                    report_mismatch("last_of_run", last_of_run, want.last);
            end
        end
    end

    // output side: random stall per beat, plus a long hold-off on request
    initial
    begin : ready_driver
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_len = 0;
            end
            stall = rush_output ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // offer one input beat and wait for it to be taken
    task automatic send_item(input logic [BYTE_W-1:0] b, input bit has, input bit eos);
        int unsigned gap;
        gap = rush_input ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        char_byte     <= b;
        has_char      <= has;
        end_of_string <= eos;
        do @(posedge clk); while (!in_ready);
        predict_grams(b, has, eos);
    endtask

    task automatic send_char(input logic [BYTE_W-1:0] b, input bit eos);
        send_item(b, 1'b1, eos);
    endtask

    // beat without a byte; the byte lines carry noise
    task automatic send_mark(input bit eos);
        send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, eos);
    endtask

    // stop offering and wait until every expected gram has come out
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_grams.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_GRAM_LENGTH:    cfg_gram_len = val[QLEN_W-1:0];
            CFG_EXTENDED_MODE:  cfg_ext      = val[0];
            CFG_START_PAD_CHAR: cfg_spad     = val;
            CFG_END_PAD_CHAR:   cfg_epad     = val;
            CFG_UNIQUE_MODE:    cfg_uniq     = val[0];
            default: ;
        endcase
    endtask

    // let the block go quiet (items may leave no gram behind), then reprogram
    task automatic set_config(input int len, input bit ext, input logic [BYTE_W-1:0] spad,
                              input logic [BYTE_W-1:0] epad, input bit uniq);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_GRAM_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_EXTENDED_MODE, CFG_DATA_W'(ext));
        write_reg(CFG_START_PAD_CHAR, spad);
        write_reg(CFG_END_PAD_CHAR, epad);
        write_reg(CFG_UNIQUE_MODE, CFG_DATA_W'(uniq));
    endtask

    // reset settings: bigrams, no padding, duplicates dropped
    task automatic test_default_config();
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h80, 1'b0);
        send_mark(1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h7F, 1'b1);
        // empty string outside extended mode
        send_mark(1'b1);
        send_char(8'h01, 1'b1);
    endtask

    // register extremes, padding, zero pad bytes and gram length zero
    task automatic test_config_extremes();
        set_config(3, 1'b1, 8'h00, 8'hFF, 1'b0);
        send_mark(1'b1);
        send_char(8'h01, 1'b1);
        set_config(1, 1'b1, 8'hFF, 8'h00, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h01, 1'b1);
        set_config(0, 1'b1, 8'd35, 8'd36, 1'b1);
        send_char(8'h55, 1'b0);
        send_char(8'hAA, 1'b0);
        send_mark(1'b1);
        set_config(2, 1'b1, 8'hFF, 8'h00, 1'b1);
        send_mark(1'b1);
        send_char(8'h80, 1'b1);
    endtask

    // window keeps its bytes across a gram length change inside a string
    task automatic test_length_change();
        set_config(3, 1'b0, 8'd35, 8'd36, 1'b1);
        send_char(8'h10, 1'b0);
        send_char(8'h20, 1'b0);
        send_char(8'h30, 1'b0);
        set_config(1, 1'b0, 8'd35, 8'd36, 1'b1);
        send_char(8'h40, 1'b0);
        set_config(2, 1'b0, 8'd35, 8'd36, 1'b1);
        send_char(8'h50, 1'b1);
    endtask

    // overflow the seen store with one long string of trigrams
    task automatic test_store_full();
        int i;
        set_config(3, 1'b0, 8'd35, 8'd36, 1'b1);
        for (i = 0; i < STORE_DEPTH + 16; i++)
            send_char(BYTE_W'($urandom_range(1, 255)), i == STORE_DEPTH + 15);
    endtask

    // receiver holds off while the sender keeps going, then sender pauses
    task automatic test_output_backpressure();
        int i;
        set_config(1, 1'b1, 8'd35, 8'd36, 1'b0);
        rush_input = 1'b1;
        hold_len   = HOLD_CYCLES;
        for (i = 0; i < 40; i++)
            send_char(BYTE_W'($urandom_range(1, 255)), i == 39);
        rush_input = 1'b0;
        wait_for_results();
    endtask

    // random strings over several register settings
    task automatic test_random_strings();
        logic [BYTE_W-1:0] few[4] = '{8'h01, 8'h41, 8'h80, 8'hFF};
        int                phase;
        int                budget;
        int                sent;
        int                len;
        int                i;
        int                q;
        bit                bare_end;
        logic [BYTE_W-1:0] spad;
        logic [BYTE_W-1:0] epad;
        logic [BYTE_W-1:0] b;
        for (phase = 0; phase < 9; phase++)
        begin
            q = (phase == 4) ? 0 : $urandom_range(1, 3);
            if (phase % 3 == 0)
            begin
                spad = (phase == 3) ? 8'hFF : 8'h00;
                epad = ~spad;
            end
            else
            begin
                spad = BYTE_W'($urandom_range(0, 255));
                epad = BYTE_W'($urandom_range(0, 255));
            end
            set_config(q, 1'($urandom_range(0, 1)), spad, epad, 1'($urandom_range(0, 1)));
            rush_output = (phase == 2);
            rush_input  = (phase == 2 || phase == 6);
            budget      = (q == 0) ? 15 : 20;
            sent        = 0;
            while (sent < budget)
            begin
                // now and then let everything drain before a string
                if ($urandom_range(0, 7) == 0)
                    wait_for_results();
                len      = $urandom_range(0, 12);
                bare_end = (len == 0) || ($urandom_range(0, 5) == 0);
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_mark(1'b0);
                    if ($urandom_range(0, 1) != 0)
                        b = few[$urandom_range(0, 3)];
                    else
                        b = BYTE_W'($urandom_range(1, 255));
                    send_char(b, !bare_end && i == len - 1);
                    sent++;
                end
                if (bare_end)
                    send_mark(1'b1);
            end
        end
        rush_input  = 1'b0;
        rush_output = 1'b0;
    endtask

    // main sequence
    initial
    begin
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        char_byte     = '0;
        has_char      = 1'b0;
        end_of_string = 1'b0;
        rush_input    = 1'b0;
        rush_output   = 1'b0;
        hold_len      = 0;
        err_count     = 0;
        cfg_gram_len  = QLEN_W'(2);
        cfg_ext       = 1'b0;
        cfg_spad      = 8'd35;
        cfg_epad      = 8'd36;
        cfg_uniq      = 1'b1;
        clear_string();
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_default_config();
        test_config_extremes();
        test_length_change();
        test_store_full();
        test_output_backpressure();
        test_random_strings();

        // drain and watch for stray grams
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_grams.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/qhd_pkg.sv
design/qhd_ctrl.sv
design/qhd_datapath.sv
design/qgram_hash_dedup.sv
sim/tb_top.sv
